// ----- src/etf_pkg.sv -----
// ----------------------------------------------------------------------------
// etf_pkg
// shared types, constants and the crc-32 byte update of the transmit framer
// ----------------------------------------------------------------------------
package etf_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] REG_DEST_MAC   = 3'd0;
  localparam logic [2:0] REG_SRC_MAC    = 3'd1;
  localparam logic [2:0] REG_ETHER_TYPE = 3'd2;
  localparam logic [2:0] REG_MIN_IFG    = 3'd3;

  localparam logic [5:0]  MAX_MIN_IFG   = 6'd32;
  localparam logic [63:0] PREAMBLE_WORD = 64'hFB55_5555_5555_55D5;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY_REFL = 32'hEDB8_8320;
  localparam logic [7:0]  IDLE_BYTE     = 8'h07;
  localparam int unsigned FIFO_DEPTH    = 4;

  // byte kind codes
  localparam logic [2:0] KIND_PRE  = 3'd0;
  localparam logic [2:0] KIND_HDR  = 3'd1;
  localparam logic [2:0] KIND_PAY  = 3'd2;
  localparam logic [2:0] KIND_FCS  = 3'd3;
  localparam logic [2:0] KIND_IDLE = 3'd4;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
    logic [5:0]  min_ifg;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;
  } entry_t;

  // queue status toward the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_out_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- src/etf_front.sv -----
// ----------------------------------------------------------------------------
// etf_front
// configuration registers and input classification (first byte of a frame)
// ----------------------------------------------------------------------------
module etf_front import etf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_data_i,
  input  logic        in_last_i,
  input  logic        q_full_i,
  output logic        push_o,
  output entry_t      push_entry_o,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic in_frame_q, in_frame_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign push_o      = in_valid_i && !q_full_i;
  assign cfg_o       = cfg_q;

  // tag each word with its frame position
  assign push_entry_o = '{data: in_data_i, last: in_last_i, first: !in_frame_q};

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEST_MAC:   cfg_d.dest_mac   = cfg_data_i;
        REG_SRC_MAC:    cfg_d.src_mac    = cfg_data_i;
        REG_ETHER_TYPE: cfg_d.ether_type = cfg_data_i[15:0];
        REG_MIN_IFG:    cfg_d.min_ifg    = cfg_data_i[5:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  // frame tracking
  always_comb begin
    in_frame_d = in_frame_q;
    if (push_o) begin
      in_frame_d = !in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= '{dest_mac: 48'd0, src_mac: 48'd0, ether_type: 16'hAEFE, min_ifg: 6'd12};
      in_frame_q <= 1'b0;
    end else begin
      cfg_q      <= cfg_d;
      in_frame_q <= in_frame_d;
    end
  end

endmodule

// ----- src/etf_queue.sv -----
// ----------------------------------------------------------------------------
// etf_queue
// small fifo between the classifying front end and the byte sequencer
// ----------------------------------------------------------------------------
module etf_queue import etf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  entry_t     push_entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output queue_out_t q_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);

  entry_t           mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    count_q, count_d;

  assign full_o      = (count_q == (PtrW+1)'(FIFO_DEPTH));
  assign q_o.valid   = (count_q != '0);
  assign q_o.entry   = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- src/etf_back.sv -----
// ----------------------------------------------------------------------------
// etf_back
// byte sequencer: preamble, header, payload, fcs and idle gap, with crc-32
// ----------------------------------------------------------------------------
module etf_back import etf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  queue_out_t q_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] out_kind_o,
  output logic       out_last_o
);

  typedef enum logic [5:0] {
    ST_WAIT = 6'b000001,
    ST_PRE  = 6'b000010,
    ST_HDR  = 6'b000100,
    ST_DATA = 6'b001000,
    ST_FCS  = 6'b010000,
    ST_GAP  = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] crc_q, crc_d;
  logic [1:0]  phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic [2:0]  kind_q, kind_d;
  logic        last_q, last_d;

  logic        adv;
  logic        do_payload;
  logic [111:0] hdr_vec;
  logic [31:0] fcs;
  logic [5:0]  gap;
  logic [1:0]  phase_end;
  logic [1:0]  pad;
  logic [5:0]  idle_total;

  assign adv         = !out_valid_q || out_ready_i;
  assign hdr_vec     = {cfg_i.dest_mac, cfg_i.src_mac, cfg_i.ether_type};
  assign fcs         = ~crc_q;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign out_kind_o  = kind_q;
  assign out_last_o  = last_q;

  // idle count for the gap, rounded to whole words
  always_comb begin
    gap        = (cfg_i.min_ifg > MAX_MIN_IFG) ? MAX_MIN_IFG : cfg_i.min_ifg;
    phase_end  = phase_q + 2'd1;
    pad        = 2'(2'd0 - (phase_end + gap[1:0]));
    idle_total = gap + {4'd0, pad};
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    phase_d     = phase_q;
    byte_d      = byte_q;
    kind_d      = kind_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    do_payload  = 1'b0;

    if (adv) begin
      out_valid_d = 1'b0;
      case (state_q)
        ST_WAIT: begin
          if (q_i.valid) begin
            if (q_i.entry.first) begin
              out_valid_d = 1'b1;
              byte_d      = PREAMBLE_WORD[63:56];
              kind_d      = KIND_PRE;
              last_d      = 1'b0;
              crc_d       = CRC_INIT;
              phase_d     = 2'd1;
              cnt_d       = 6'd1;
              state_d     = ST_PRE;
            end else begin
              do_payload = 1'b1;
            end
          end
        end
        ST_PRE: begin
          out_valid_d = 1'b1;
          byte_d      = PREAMBLE_WORD[63 - 8*cnt_q[2:0] -: 8];
          kind_d      = KIND_PRE;
          last_d      = 1'b0;
          phase_d     = phase_q + 2'd1;
          if (cnt_q[2:0] == 3'd7) begin
            cnt_d   = '0;
            state_d = ST_HDR;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
        ST_HDR: begin
          out_valid_d = 1'b1;
          byte_d      = hdr_vec[111 - 8*cnt_q[3:0] -: 8];
          kind_d      = KIND_HDR;
          last_d      = 1'b0;
          crc_d       = crc32_byte(crc_q, hdr_vec[111 - 8*cnt_q[3:0] -: 8]);
          phase_d     = phase_q + 2'd1;
          if (cnt_q[3:0] == 4'd13) begin
            cnt_d   = '0;
            state_d = ST_DATA;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
        ST_DATA: begin
          do_payload = q_i.valid;
        end
        ST_FCS: begin
          out_valid_d = 1'b1;
          byte_d      = fcs[8*cnt_q[1:0] +: 8];
          kind_d      = KIND_FCS;
          last_d      = 1'b0;
          phase_d     = phase_q + 2'd1;
          if (cnt_q[1:0] == 2'd3) begin
            if (idle_total == '0) begin
              last_d  = 1'b1;
              crc_d   = CRC_INIT;
              phase_d = 2'd0;
              state_d = ST_WAIT;
            end else begin
              cnt_d   = idle_total - 6'd1;
              state_d = ST_GAP;
            end
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
        ST_GAP: begin
          out_valid_d = 1'b1;
          byte_d      = IDLE_BYTE;
          kind_d      = KIND_IDLE;
          if (cnt_q == '0) begin
            last_d  = 1'b1;
            crc_d   = CRC_INIT;
            phase_d = 2'd0;
            state_d = ST_WAIT;
          end else begin
            last_d = 1'b0;
            cnt_d  = cnt_q - 6'd1;
          end
        end
        default: begin
          state_d = ST_WAIT;
        end
      endcase

      // payload word leaves the queue
      if (do_payload) begin
        pop_o       = 1'b1;
        out_valid_d = 1'b1;
        byte_d      = q_i.entry.data;
        kind_d      = KIND_PAY;
        crc_d       = crc32_byte(crc_q, q_i.entry.data);
        phase_d     = phase_q + 2'd1;
        if (q_i.entry.last) begin
          last_d  = 1'b0;
          cnt_d   = '0;
          state_d = ST_FCS;
        end else begin
          last_d  = 1'b1;
          state_d = ST_WAIT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WAIT;
      cnt_q       <= '0;
      crc_q       <= CRC_INIT;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      crc_q       <= crc_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    kind_q <= kind_d;
    last_q <= last_d;
  end

endmodule

// ----- src/ethernet_tx_framer.sv -----
// ----------------------------------------------------------------------------
// ethernet_tx_framer
// an accepted word is written into the queue, then loaded into the output register
// throughput: one output byte per cycle while m_axis_tready is high; payload words
// go one per cycle mid-frame; a first word adds the preamble and header bytes
// a last word adds the 4 fcs bytes plus the idle gap
// reset: asynchronous, clears control state and loads register reset values
// ----------------------------------------------------------------------------
module ethernet_tx_framer import etf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
  input  logic        s_axis_tlast,   // frame_last
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
  output logic [2:0]  m_axis_tuser,   // [2:0] byte_kind
  output logic        m_axis_tlast    // run_last
);

  cfg_t       cfg;
  entry_t     push_entry;
  logic       push;
  logic       q_full;
  logic       pop;
  queue_out_t q_out;

  // classification and registers
  etf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry),
    .cfg_o        (cfg)
  );

  // decoupling queue
  etf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .q_o          (q_out)
  );

  // byte sequencer
  etf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_i         (q_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ethernet transmit framer: a directed table of
// frames and register writes, then random frames under three handshake idle
// mixes; every output word is checked against a cycle-free frame predictor
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etf_pkg::*;

  // register indexes that the block does not decode
  localparam logic [2:0] REG_SPARE_LO = 3'd4;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MODE_ITEMS     = 56;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       last;
  } link_word_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // nres: words the item must cause, 0 leaves it to the predictor
  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [47:0] data;
    logic [7:0]  pb;
    logic        last;
    logic [7:0]  nres;
  } plan_row_t;

  localparam int PLAN_LEN = 22;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // reset settings: 3-byte frame, then a one-byte frame
    '{ROW_ITEM, '0, '0, 8'h00, 1'b0, 8'd23},
    '{ROW_ITEM, '0, '0, 8'hFF, 1'b0, 8'd1},
    '{ROW_ITEM, '0, '0, 8'hA5, 1'b1, 8'd20},
    '{ROW_ITEM, '0, '0, 8'h5A, 1'b1, 8'd40},
    // all-ones header, no gap, write to an undecoded index
    '{ROW_CFG, REG_DEST_MAC,   48'hFFFF_FFFF_FFFF, '0, '0, '0},
    '{ROW_CFG, REG_SRC_MAC,    48'hFFFF_FFFF_FFFF, '0, '0, '0},
    '{ROW_CFG, REG_ETHER_TYPE, 48'h0000_0000_FFFF, '0, '0, '0},
    '{ROW_CFG, REG_MIN_IFG,    48'h0000_0000_0000, '0, '0, '0},
    '{ROW_CFG, REG_SPARE_HI,   48'hFFFF_FFFF_FFFF, '0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h80, 1'b1, 8'd28},
    '{ROW_ITEM, '0, '0, 8'h01, 1'b0, 8'd23},
    '{ROW_ITEM, '0, '0, 8'h7F, 1'b1, 8'd5},
    // gap above the ceiling saturates
    '{ROW_CFG, REG_MIN_IFG,    48'h0000_0000_003F, '0, '0, '0},
    '{ROW_CFG, REG_DEST_MAC,   48'h0000_0000_0000, '0, '0, '0},
    '{ROW_CFG, REG_ETHER_TYPE, 48'h0000_0000_0000, '0, '0, '0},
    '{ROW_CFG, REG_SRC_MAC,    48'h0123_4567_89AB, '0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'hC3, 1'b1, 8'd60},
    '{ROW_ITEM, '0, '0, 8'h00, 1'b0, 8'd23},
    '{ROW_ITEM, '0, '0, 8'hFF, 1'b0, 8'd1},
    '{ROW_ITEM, '0, '0, 8'hAA, 1'b1, 8'd40},
    '{ROW_CFG, REG_MIN_IFG,    48'h0000_0000_0021, '0, '0, '0},
    '{ROW_ITEM, '0, '0, 8'h3C, 1'b1, 8'd60}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = '0;
  logic [47:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] payload_byte
  logic        s_axis_tlast  = 1'b0; // frame_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] tx_byte
  logic [2:0]  m_axis_tuser;         // [2:0] byte_kind
  logic        m_axis_tlast;         // run_last

  // predictor state and register shadow
  logic        fr_open  = 1'b0;
  logic [31:0] fcs_acc  = CRC_INIT;
  int unsigned fr_phase = 0;
  logic [47:0] sh_dest  = '0;
  logic [47:0] sh_src   = '0;
  logic [15:0] sh_type  = 16'hAEFE;
  logic [5:0]  sh_ifg   = 6'd12;

  link_word_t link_expect[$];
  int         run_len_expect[$];
  int         item_nres      = 0;
  int         run_seen       = 0;
  int         err_cnt        = 0;
  int         quiet_cycles   = 0;
  int         send_gap_pct   = 0;
  int         recv_stall_pct = 0;

  ethernet_tx_framer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // one expected link byte; header and payload bytes go into the fcs
  function automatic void put_byte(input logic [7:0] b, input logic [2:0] kind,
                                   input bit fold);
    logic [31:0] c;
    link_word_t  w;
    if (fold) begin
      c = fcs_acc ^ {24'd0, b};
      for (int j = 0; j < 8; j++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      fcs_acc = c;
    end
    w.data = b;
    w.kind = kind;
    w.last = 1'b0;
    link_expect = {link_expect, w};
    if (kind != KIND_IDLE) begin
      fr_phase = (fr_phase + 1) & 3;
    end
  endfunction

  // all link bytes caused by one payload byte
  function automatic void frame_bytes(input logic [7:0] pb, input logic last);
    logic [31:0] fcs;
    int unsigned gap;
    int unsigned pad;
    link_word_t  tail;
    if (!fr_open) begin
      fcs_acc  = CRC_INIT;
      fr_phase = 0;
      for (int i = 7; i >= 0; i--) put_byte(PREAMBLE_WORD[8*i +: 8], KIND_PRE, 1'b0);
      for (int i = 5; i >= 0; i--) put_byte(sh_dest[8*i +: 8], KIND_HDR, 1'b1);
      for (int i = 5; i >= 0; i--) put_byte(sh_src[8*i +: 8], KIND_HDR, 1'b1);
      put_byte(sh_type[15:8], KIND_HDR, 1'b1);
      put_byte(sh_type[7:0], KIND_HDR, 1'b1);
      fr_open = 1'b1;
    end
    put_byte(pb, KIND_PAY, 1'b1);
    if (last) begin
      fcs = ~fcs_acc;
      gap = (sh_ifg > MAX_MIN_IFG) ? int'(MAX_MIN_IFG) : int'(sh_ifg);
      for (int i = 0; i < 4; i++) put_byte(fcs[8*i +: 8], KIND_FCS, 1'b0);
      // round frame plus gap up to whole 4-byte words
      pad = (4 - ((fr_phase + gap) & 3)) & 3;
      for (int k = 0; k < gap + pad; k++) put_byte(IDLE_BYTE, KIND_IDLE, 1'b0);
      fr_open  = 1'b0;
      fcs_acc  = CRC_INIT;
      fr_phase = 0;
    end
    tail = link_expect[link_expect.size() - 1];
    tail.last = 1'b1;
    link_expect[link_expect.size() - 1] = tail;
  endfunction

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    if (err_cnt < 10) begin
      $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $time);
    end
    err_cnt++;
  endtask

  // handshakes seen at the rising edge: register shadow, prediction, checks
  always @(posedge clk_i) begin : link_check
    link_word_t want;
    int         exp_len;
    if (rst_ni) begin
      quiet_cycles++;
      if (cfg_valid_i && cfg_ready_o) begin
        quiet_cycles = 0;
        case (cfg_index_i)
          REG_DEST_MAC:   sh_dest = cfg_data_i;
          REG_SRC_MAC:    sh_src  = cfg_data_i;
          REG_ETHER_TYPE: sh_type = cfg_data_i[15:0];
          REG_MIN_IFG:    sh_ifg  = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        quiet_cycles = 0;
        frame_bytes(s_axis_tdata, s_axis_tlast);
        run_len_expect = {run_len_expect, item_nres};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        run_seen++;
        if (link_expect.size() == 0) begin
          flag("word with nothing expected", '0,
               {20'd0, m_axis_tdata, m_axis_tuser, m_axis_tlast});
        end else begin
          want = link_expect.pop_front();
          if (m_axis_tdata != want.data) begin
            flag("tx_byte", 32'(want.data), 32'(m_axis_tdata));
          end
          if (m_axis_tuser != want.kind) begin
            flag("byte_kind", 32'(want.kind), 32'(m_axis_tuser));
          end
          if (m_axis_tlast != want.last) begin
            flag("run_last", 32'(want.last), 32'(m_axis_tlast));
          end
        end
        if (m_axis_tlast) begin
          if (run_len_expect.size() != 0) begin
            exp_len = run_len_expect.pop_front();
            if (exp_len != 0 && exp_len != run_seen) begin
              flag("words per item", 32'(exp_len), 32'(run_seen));
            end
          end
          run_seen = 0;
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // entered and left at a falling edge with nothing yet driven in that step
  task automatic send_item(input logic [7:0] pb, input logic last, input int nres,
                           input bit hold);
    if (hold) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      while (link_expect.size() != 0) @(negedge clk_i);
    end
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pb;
    s_axis_tlast  <= last;
    item_nres = nres;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [47:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // stop sending and let every expected word drain
  task automatic go_quiet();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (link_expect.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin : stimulus
    plan_row_t   row;
    int          flen;
    int          mode_items;
    bit          held;
    bit          hold;
    logic [47:0] r48;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    send_gap_pct   = 30;
    recv_stall_pct = 71;
    for (int r = 0; r < PLAN_LEN; r++) begin
      row = PLAN[r];
      if (row.kind == ROW_CFG) begin
        go_quiet();
        cfg_write(row.idx, row.data);
      end else begin
        send_item(row.pb, row.last, int'(row.nres), 1'b0);
      end
    end

    // random frames under three idle mixes
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_gap_pct = 30; recv_stall_pct = 71; end
        1: begin send_gap_pct = 71; recv_stall_pct = 30; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      go_quiet();
      cfg_write(REG_DEST_MAC, rand48());
      cfg_write(REG_SRC_MAC, rand48());
      cfg_write(REG_ETHER_TYPE, rand48());
      r48 = rand48();
      r48[5:0] = 6'($urandom_range(0, 63));
      cfg_write(REG_MIN_IFG, r48);
      cfg_write(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), rand48());
      mode_items = 0;
      held       = 1'b0;
      while (mode_items < MODE_ITEMS) begin
        case ($urandom_range(0, 99)) inside
          [0:69]:  flen = $urandom_range(1, 6);
          [70:94]: flen = $urandom_range(7, 20);
          default: flen = $urandom_range(21, 48);
        endcase
        // the last frame of a mix ends on the item budget
        if (flen > MODE_ITEMS - mode_items) flen = MODE_ITEMS - mode_items;
        for (int k = 0; k < flen; k++) begin
          // one pause per mix until the link drains, preferably mid-frame
          hold = !held && mode_items >= 20 && (k > 0 || mode_items >= 40);
          if (hold) held = 1'b1;
          send_item(8'($urandom_range(0, 255)), k == flen - 1, 0, hold);
          mode_items++;
        end
      end
    end

    go_quiet();
    repeat (8) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/etf_pkg.sv
src/etf_front.sv
src/etf_queue.sv
src/etf_back.sv
src/ethernet_tx_framer.sv
tb/sv/tb.sv
